// ----- hdl/jsu_pkg.sv -----
// Shared types, constants and helper functions for the JSON string unescape block.
`timescale 1ns / 1ps
`default_nettype none

package jsu_pkg;

    // Result codes
    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_CLOSE = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // Most results one input byte can produce: four data bytes and an error
    localparam int RUN_MAX = 5;
    localparam int RUN_W   = 3;

    // Characters of interest
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Surrogate ranges
    localparam logic [15:0] HI_SUR_MIN = 16'hD800;
    localparam logic [15:0] HI_SUR_MAX = 16'hDBFF;
    localparam logic [15:0] LO_SUR_MIN = 16'hDC00;
    localparam logic [15:0] LO_SUR_MAX = 16'hDFFF;
    localparam logic [20:0] SUPP_BASE  = 21'h10000;

    // Range codes for the next UTF-8 continuation byte
    localparam logic [2:0] LIM_NONE  = 3'd0;
    localparam logic [2:0] LIM_A0_BF = 3'd1;
    localparam logic [2:0] LIM_80_9F = 3'd2;
    localparam logic [2:0] LIM_90_BF = 3'd3;
    localparam logic [2:0] LIM_80_8F = 3'd4;

    typedef enum logic [6:0] {
        PH_WAIT = 7'b0000001,
        PH_BODY = 7'b0000010,
        PH_ESC  = 7'b0000100,
        PH_HEX  = 7'b0001000,
        PH_BSL  = 7'b0010000,
        PH_U    = 7'b0100000,
        PH_LOW  = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       doc_end;
    } in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] kind;
        logic       last_of_run;
    } out_t;

    // All results caused by one input byte
    typedef struct packed {
        out_t [RUN_MAX-1:0] res;
    } run_t;

    typedef struct packed {
        phase_t      phase;
        logic [15:0] hex_acc;
        logic [1:0]  hex_cnt;
        logic [9:0]  hi_bits;
        logic [1:0]  utf8_pend;
        logic [2:0]  utf8_lim;
    } dec_state_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } hex_t;

    typedef struct packed {
        logic       ok;
        logic [1:0] pend;
        logic [2:0] lim;
    } utf8_chk_t;

    // Hex digit decode
    function automatic hex_t hex_value(input logic [7:0] b);
        hex_t h;
        h.valid = 1'b1;
        h.value = 4'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            h.value = 4'(b - 8'h30);
        end else if (b >= 8'h61 && b <= 8'h66) begin
            h.value = 4'(b - 8'h57);
        end else if (b >= 8'h41 && b <= 8'h46) begin
            h.value = 4'(b - 8'h37);
        end else begin
            h.valid = 1'b0;
        end
        return h;
    endfunction

    // One step of the UTF-8 well-formedness tracker
    function automatic utf8_chk_t utf8_check(input logic [1:0] pend, input logic [2:0] lim,
                                             input logic [7:0] b);
        utf8_chk_t  c;
        logic [7:0] lo;
        logic [7:0] hi;
        c.ok   = 1'b1;
        c.pend = pend;
        c.lim  = LIM_NONE;
        lo     = 8'h80;
        hi     = 8'hBF;
        if (pend != 2'd0) begin
            case (lim)
                LIM_A0_BF: lo = 8'hA0;
                LIM_80_9F: hi = 8'h9F;
                LIM_90_BF: lo = 8'h90;
                LIM_80_8F: hi = 8'h8F;
                default:   lo = 8'h80;
            endcase
            c.ok   = (b >= lo) && (b <= hi);
            c.pend = pend - 2'd1;
        end else if (b < 8'h80) begin
            c.ok = 1'b1;
        end else if (b < 8'hC2) begin
            c.ok = 1'b0;
        end else if (b < 8'hE0) begin
            c.pend = 2'd1;
        end else if (b < 8'hF0) begin
            c.pend = 2'd2;
            if (b == 8'hE0) begin
                c.lim = LIM_A0_BF;
            end else if (b == 8'hED) begin
                c.lim = LIM_80_9F;
            end
        end else if (b < 8'hF5) begin
            c.pend = 2'd3;
            if (b == 8'hF0) begin
                c.lim = LIM_90_BF;
            end else if (b == 8'hF4) begin
                c.lim = LIM_80_8F;
            end
        end else begin
            c.ok = 1'b0;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/json_string_unescape_utf8.sv -----
// Top level of the JSON string literal to UTF-8 decoder.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-------------------------------------
//  s_      | in  | s_valid / s_ready  | in_t  {in_byte, doc_end}
//  m_      | out | m_valid / m_ready  | out_t {out_byte, kind, last_of_run}
//
// One document byte is taken per cycle while the queue has room for its run.
// A byte is held in the input register, decoded there, and its run of 0 to 5
// results is written to a queue of QUEUE_DEPTH runs; results leave at one per
// cycle while m_ready is high.
// The result port rate sets the sustained figure when runs hold more than one result.
// Reset clears the decoder state to waiting for an opening quote and empties
// the queue. When the queue is full, a byte that yields results holds in the input register until a run is drained.
`timescale 1ns / 1ps
`default_nettype none

module json_string_unescape_utf8
    import jsu_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    logic             in_vld_reg;
    in_t              in_reg;
    dec_state_t       state_reg;
    dec_state_t       state_next;
    run_t             run;
    logic [RUN_W-1:0] run_n;
    logic             q_full;
    logic             adv;
    logic             push;

    // Decode the registered byte against the current string state
    jsu_decode u_decode (
        .st    (state_reg),
        .din   (in_reg),
        .nxt   (state_next),
        .run   (run),
        .run_n (run_n)
    );

    // Byte leaves the input register when its run fits in the queue
    assign adv     = in_vld_reg && (!q_full || run_n == '0);
    assign push    = adv && (run_n != '0);
    assign s_ready = !in_vld_reg || adv;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_vld_reg <= 1'b1;
        end else if (adv) begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
    end

    // Decoder state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase     <= PH_WAIT;
            state_reg.hex_acc   <= '0;
            state_reg.hex_cnt   <= '0;
            state_reg.hi_bits   <= '0;
            state_reg.utf8_pend <= '0;
            state_reg.utf8_lim  <= LIM_NONE;
        end else if (adv) begin
            state_reg <= state_next;
        end
    end

    // Result queue
    jsu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_run (run),
        .full     (q_full),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    // A pushed run is visible on the result port next cycle
    assert property (@(posedge aclk) disable iff (!aresetn) push |=> m_valid)
        else $error("pushed run not visible on result port");

    // A blocked byte stays in the input register untouched
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_vld_reg && !adv) |=> (in_vld_reg && $stable(in_reg)))
        else $error("blocked input transaction lost or changed");

    // Close and error results carry a zero byte and end their run
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.kind != KIND_DATA) |-> (m_data.out_byte == 8'h00 && m_data.last_of_run))
        else $error("close or error result malformed");

    // Waiting for a string implies no open UTF-8 sequence
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.phase == PH_WAIT) |-> (state_reg.utf8_pend == 2'd0))
        else $error("string state not cleared in wait phase");

endmodule

`default_nettype wire

// ----- hdl/jsu_decode.sv -----
// Combinational decode of one document byte into its run of results and the next state.
`timescale 1ns / 1ps
`default_nettype none

module jsu_decode
    import jsu_pkg::*;
(
    input  dec_state_t       st,
    input  in_t              din,
    output dec_state_t       nxt,
    output run_t             run,
    output logic [RUN_W-1:0] run_n
);

    hex_t             hv;
    logic [15:0]      acc_new;
    logic [20:0]      cp;
    logic             emit_single;
    logic             emit_cp;
    logic [7:0]       single_byte;
    logic [2:0]       nb;
    logic [7:0]       bytes [4];
    logic             bad_pre;
    logic             bad_u;
    logic             close;
    logic             fault;
    logic [1:0]       cur_pend;
    logic [2:0]       cur_lim;
    utf8_chk_t        chk;
    logic [RUN_W-1:0] n;

    // Phase handling, UTF-8 encode and check, then close or error
    always_comb begin
        nxt         = st;
        run         = '0;
        n           = '0;
        emit_single = 1'b0;
        emit_cp     = 1'b0;
        single_byte = din.in_byte;
        cp          = '0;
        bad_pre     = 1'b0;
        bad_u       = 1'b0;
        close       = 1'b0;
        hv          = hex_value(din.in_byte);
        acc_new     = {st.hex_acc[11:0], hv.value};
        nb          = 3'd0;
        for (int i = 0; i < 4; i++) begin
            bytes[i] = 8'h00;
        end

        unique case (st.phase) inside
            PH_BODY: begin
                if (din.in_byte == CH_QUOTE) begin
                    if (st.utf8_pend != 2'd0) begin
                        bad_pre = 1'b1;
                    end else begin
                        close     = 1'b1;
                        nxt.phase = PH_WAIT;
                    end
                end else if (din.in_byte < CH_SPACE) begin
                    bad_pre = 1'b1;
                end else if (din.in_byte == CH_BSL) begin
                    nxt.phase = PH_ESC;
                end else begin
                    emit_single = 1'b1;
                end
            end
            PH_ESC: begin
                nxt.phase = PH_BODY;
                unique case (din.in_byte) inside
                    CH_QUOTE, CH_BSL, CH_SLASH: emit_single = 1'b1;
                    CH_B: begin
                        emit_single = 1'b1;
                        single_byte = 8'h08;
                    end
                    CH_F: begin
                        emit_single = 1'b1;
                        single_byte = 8'h0C;
                    end
                    CH_N: begin
                        emit_single = 1'b1;
                        single_byte = 8'h0A;
                    end
                    CH_R: begin
                        emit_single = 1'b1;
                        single_byte = 8'h0D;
                    end
                    CH_T: begin
                        emit_single = 1'b1;
                        single_byte = 8'h09;
                    end
                    CH_U: begin
                        nxt.hex_acc = '0;
                        nxt.hex_cnt = '0;
                        nxt.phase   = PH_HEX;
                    end
                    default: bad_pre = 1'b1;
                endcase
            end
            PH_HEX, PH_LOW: begin
                if (!hv.valid) begin
                    bad_pre = 1'b1;
                end else if (st.hex_cnt != 2'd3) begin
                    nxt.hex_acc = acc_new;
                    nxt.hex_cnt = st.hex_cnt + 2'd1;
                end else begin
                    nxt.hex_acc = acc_new;
                    nxt.hex_cnt = '0;
                    if (st.phase == PH_HEX) begin
                        if (acc_new >= HI_SUR_MIN && acc_new <= HI_SUR_MAX) begin
                            nxt.hi_bits = acc_new[9:0];
                            nxt.phase   = PH_BSL;
                        end else if (acc_new >= LO_SUR_MIN && acc_new <= LO_SUR_MAX) begin
                            bad_pre = 1'b1;
                        end else begin
                            emit_cp   = 1'b1;
                            cp        = {5'd0, acc_new};
                            nxt.phase = PH_BODY;
                        end
                    end else begin
                        if (acc_new < LO_SUR_MIN || acc_new > LO_SUR_MAX) begin
                            bad_pre = 1'b1;
                        end else begin
                            emit_cp   = 1'b1;
                            cp        = SUPP_BASE + 21'({st.hi_bits, acc_new[9:0]});
                            nxt.phase = PH_BODY;
                        end
                    end
                end
            end
            PH_BSL: begin
                if (din.in_byte == CH_BSL) begin
                    nxt.phase = PH_U;
                end else begin
                    bad_pre = 1'b1;
                end
            end
            PH_U: begin
                if (din.in_byte == CH_U) begin
                    nxt.hex_acc = '0;
                    nxt.hex_cnt = '0;
                    nxt.phase   = PH_LOW;
                end else begin
                    bad_pre = 1'b1;
                end
            end
            default: begin
                nxt.phase = PH_WAIT;
                if (din.in_byte == CH_QUOTE) begin
                    nxt.phase = PH_BODY;
                end else begin
                    bad_pre = 1'b1;
                end
            end
        endcase

        // UTF-8 encode of the bytes to emit
        if (emit_single) begin
            nb       = 3'd1;
            bytes[0] = single_byte;
        end else if (emit_cp) begin
            if (cp < 21'h80) begin
                nb       = 3'd1;
                bytes[0] = cp[7:0];
            end else if (cp < 21'h800) begin
                nb       = 3'd2;
                bytes[0] = {3'b110, cp[10:6]};
                bytes[1] = {2'b10, cp[5:0]};
            end else if (cp < 21'h10000) begin
                nb       = 3'd3;
                bytes[0] = {4'b1110, cp[15:12]};
                bytes[1] = {2'b10, cp[11:6]};
                bytes[2] = {2'b10, cp[5:0]};
            end else begin
                nb       = 3'd4;
                bytes[0] = {5'b11110, cp[20:18]};
                bytes[1] = {2'b10, cp[17:12]};
                bytes[2] = {2'b10, cp[11:6]};
                bytes[3] = {2'b10, cp[5:0]};
            end
        end

        // Well-formedness check, byte by byte; stop at the first bad one
        cur_pend = st.utf8_pend;
        cur_lim  = st.utf8_lim;
        chk      = '0;
        for (int i = 0; i < 4; i++) begin
            if (3'(i) < nb && !bad_u) begin
                chk = utf8_check(cur_pend, cur_lim, bytes[i]);
                if (chk.ok) begin
                    cur_pend                = chk.pend;
                    cur_lim                 = chk.lim;
                    run.res[i].out_byte     = bytes[i];
                    run.res[i].kind         = KIND_DATA;
                    run.res[i].last_of_run  = 1'b0;
                    n                       = RUN_W'(i + 1);
                end else begin
                    bad_u = 1'b1;
                end
            end
        end
        nxt.utf8_pend = cur_pend;
        nxt.utf8_lim  = cur_lim;

        // Close, error, and clearing of the string state
        fault = bad_pre || bad_u || (din.doc_end && nxt.phase != PH_WAIT);
        if (close) begin
            run.res[0].out_byte    = 8'h00;
            run.res[0].kind        = KIND_CLOSE;
            run.res[0].last_of_run = 1'b0;
            n                      = RUN_W'(1);
        end
        if (fault) begin
            run.res[n].out_byte    = 8'h00;
            run.res[n].kind        = KIND_ERROR;
            run.res[n].last_of_run = 1'b0;
            n                      = n + RUN_W'(1);
            nxt.phase              = PH_WAIT;
        end
        if (close || fault) begin
            nxt.hex_acc   = '0;
            nxt.hex_cnt   = '0;
            nxt.hi_bits   = '0;
            nxt.utf8_pend = '0;
            nxt.utf8_lim  = LIM_NONE;
        end

        // Mark the final result of the run
        for (int i = 0; i < RUN_MAX; i++) begin
            run.res[i].last_of_run = (n != '0) && (RUN_W'(i + 1) == n);
        end
    end

    assign run_n = n;

endmodule

`default_nettype wire

// ----- hdl/jsu_queue.sv -----
// Queue of decoded runs, unpacked onto the result channel one result at a time.
`timescale 1ns / 1ps
`default_nettype none

module jsu_queue
    import jsu_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  run_t push_run,
    output logic full,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    run_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [RUN_W-1:0] idx_reg;
    run_t             head;
    logic             take;
    logic             pop;

    assign head    = slot_reg[rd_ptr_reg];
    assign m_valid = (count_reg != '0);
    assign m_data  = head.res[idx_reg];
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign take    = m_valid && m_ready;
    assign pop     = take && m_data.last_of_run;

    // Run storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_run;
        end
    end

    // Pointers, fill count and position within the head run
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            idx_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
            if (pop) begin
                idx_reg <= '0;
            end else if (take) begin
                idx_reg <= idx_reg + RUN_W'(1);
            end
        end
    end

endmodule

`default_nettype wire
